// File: src/lrd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lrd_pkg;

	// Pipeline depth of each section, in cycles.
	localparam int SETUP_LAT = 6;
	localparam int DIV_STEPS = 32;
	localparam int DIV_LAT   = DIV_STEPS + 2;
	localparam int POINT_LAT = 5;
	localparam int SQRT_LAT  = 21;
	localparam int PIPE_LAT  = SETUP_LAT + DIV_LAT + POINT_LAT + SQRT_LAT;

	localparam logic [28:0]        TOL_RESET = 29'd268;
	localparam logic signed [15:0] DIR_ONE   = 16'sd16384;
	localparam logic [41:0]        SQ_MAX    = 42'h3ffffffffff;

	typedef struct packed {
		logic signed [19:0] line_origin_x;
		logic signed [19:0] line_origin_y;
		logic signed [19:0] line_origin_z;
		logic signed [15:0] line_dir_x;
		logic signed [15:0] line_dir_y;
		logic signed [15:0] line_dir_z;
		logic signed [19:0] ray_origin_x;
		logic signed [19:0] ray_origin_y;
		logic signed [19:0] ray_origin_z;
		logic signed [15:0] ray_dir_x;
		logic signed [15:0] ray_dir_y;
		logic signed [15:0] ray_dir_z;
	} query_t;

	typedef struct packed {
		logic [41:0]        squared_distance;
		logic [20:0]        distance;
		logic signed [31:0] line_param;
		logic [30:0]        ray_param;
		logic signed [31:0] near_x;
		logic signed [31:0] near_y;
		logic signed [31:0] near_z;
		logic signed [31:0] far_x;
		logic signed [31:0] far_y;
		logic signed [31:0] far_z;
	} result_t;

	// Origins and clamped directions, index 0 is x.
	typedef struct packed {
		logic [2:0][19:0] lo;
		logic [2:0][19:0] ro;
		logic [2:0][15:0] ld;
		logic [2:0][15:0] rd;
	} geom_t;

	// Data that rides alongside the dividers.
	typedef struct packed {
		geom_t              geom;
		logic signed [23:0] s0proj;
		logic               use_div;
	} side_t;

	// Setup output: numerators, determinant and sideband.
	typedef struct packed {
		side_t              side;
		logic signed [59:0] n0;
		logic signed [59:0] n1;
		logic [31:0]        det;
	} solve_t;

	// Point section output, carried alongside the square root.
	typedef struct packed {
		logic [41:0]        sq;
		logic signed [31:0] s0;
		logic [30:0]        s1;
		logic [2:0][31:0]   p0;
		logic [2:0][31:0]   p1;
	} tail_t;

endpackage

`default_nettype wire

// File: src/line_ray_distance_3d_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Closest approach between a 3D line and a 3D ray, fixed point.
// A query transaction carries both origins (Q12.8) and both unit directions
// (Q1.14); each one yields exactly one result transaction with the two
// closest-point parameters, the two closest points, the squared distance
// and its square root. Results leave in the order the queries came in.
// The parallel tolerance register is written over the cfg channel, which
// is always ready; write it only while no query is in flight.
// Throughput is one query per cycle while no result waits unaccepted.
// Each query passes through 66 register stages to result valid: 6 setup
// stages, a 32-step radix-2 divider with prep and output stages (34),
// 5 point stages and a 21-step root.
// The whole pipeline advances together: while a result sits unaccepted at
// the output, every stage holds and query_ready is low; bubbles move on
// whenever the output is empty or being taken.
// Reset clears every valid bit and loads the tolerance with 268.

module line_ray_distance_3d_core (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            query_valid,
	output logic                 query_ready,
	input  wire lrd_pkg::query_t query,
	output logic                 result_valid,
	input  wire logic            result_ready,
	output lrd_pkg::result_t     result,
	input  wire logic            cfg_valid,
	output logic                 cfg_ready,
	input  wire logic [28:0]     cfg_data
);
	import lrd_pkg::*;

	logic [28:0]         tol_q;
	logic [PIPE_LAT-1:0] vld_q;
	logic                adv;
	solve_t              solved;
	logic signed [31:0]  q0, q1;
	side_t               side_dl_q [DIV_LAT];
	tail_t               tail, tl;
	tail_t               tail_dl_q [SQRT_LAT];
	logic [20:0]         root;

	// Tolerance register.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_RESET;
		end else if (cfg_valid) begin
			tol_q <= cfg_data;
		end
	end

	// Global advance and the valid bits of every stage.
	assign adv          = !result_valid || result_ready;
	assign query_ready  = adv;
	assign result_valid = vld_q[PIPE_LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[PIPE_LAT-2:0], query_valid};
		end
	end

	lrd_setup u_setup (
		.clk    (clk),
		.en     (adv),
		.tol    (tol_q),
		.query  (query),
		.solved (solved)
	);

	lrd_div u_div0 (
		.clk (clk),
		.en  (adv),
		.num (solved.n0),
		.det (solved.det),
		.quo (q0)
	);

	lrd_div u_div1 (
		.clk (clk),
		.en  (adv),
		.num (solved.n1),
		.det (solved.det),
		.quo (q1)
	);

	// Sideband delay matching the dividers.
	always_ff @(posedge clk) begin
		if (adv) begin
			side_dl_q[0] <= solved.side;
			for (int k = 1; k < DIV_LAT; k++) begin
				side_dl_q[k] <= side_dl_q[k-1];
			end
		end
	end

	lrd_point u_point (
		.clk  (clk),
		.en   (adv),
		.side (side_dl_q[DIV_LAT-1]),
		.q0   (q0),
		.q1   (q1),
		.tail (tail)
	);

	lrd_sqrt u_sqrt (
		.clk  (clk),
		.en   (adv),
		.val  (tail.sq),
		.root (root)
	);

	// Sideband delay matching the square root.
	always_ff @(posedge clk) begin
		if (adv) begin
			tail_dl_q[0] <= tail;
			for (int k = 1; k < SQRT_LAT; k++) begin
				tail_dl_q[k] <= tail_dl_q[k-1];
			end
		end
	end

	// Result assembly.
	always_comb begin
		tl                      = tail_dl_q[SQRT_LAT-1];
		result.squared_distance = tl.sq;
		result.distance         = root;
		result.line_param       = tl.s0;
		result.ray_param        = tl.s1;
		result.near_x           = tl.p0[0];
		result.near_y           = tl.p0[1];
		result.near_z           = tl.p0[2];
		result.far_x            = tl.p1[0];
		result.far_y            = tl.p1[1];
		result.far_z            = tl.p1[2];
	end

`ifndef SYNTHESIS
	// The root must bracket the squared distance from below.
	a_root_bounds : assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |->
			(43'(result.distance) * 43'(result.distance) <= 43'(result.squared_distance)) &&
			((43'(result.distance) + 43'd1) * (43'(result.distance) + 43'd1) >
				43'(result.squared_distance)))
		else $error("distance is not the floor root of squared_distance");

	// A stalled pipeline neither drops nor creates transactions.
	a_stall_holds : assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_q))
		else $error("valid bits moved while the pipeline was stalled");
`endif

endmodule

`default_nettype wire

// File: src/lrd_setup.sv
`timescale 1ns / 1ps
`default_nettype none

module lrd_setup (
	input  wire logic            clk,
	input  wire logic            en,
	input  wire logic [28:0]     tol,
	input  wire lrd_pkg::query_t query,
	output lrd_pkg::solve_t      solved
);
	import lrd_pkg::*;

	function automatic logic signed [15:0] clamp_dir(input logic signed [15:0] d);
		if (d > DIR_ONE) begin
			clamp_dir = DIR_ONE;
		end else if (d < -DIR_ONE) begin
			clamp_dir = -DIR_ONE;
		end else begin
			clamp_dir = d;
		end
	endfunction

	logic signed [19:0] lo_in [3];
	logic signed [19:0] ro_in [3];
	logic signed [15:0] ld_in [3];
	logic signed [15:0] rd_in [3];

	assign lo_in[0] = query.line_origin_x;
	assign lo_in[1] = query.line_origin_y;
	assign lo_in[2] = query.line_origin_z;
	assign ro_in[0] = query.ray_origin_x;
	assign ro_in[1] = query.ray_origin_y;
	assign ro_in[2] = query.ray_origin_z;
	assign ld_in[0] = query.line_dir_x;
	assign ld_in[1] = query.line_dir_y;
	assign ld_in[2] = query.line_dir_z;
	assign rd_in[0] = query.ray_dir_x;
	assign rd_in[1] = query.ray_dir_y;
	assign rd_in[2] = query.ray_dir_z;

	geom_t geom_s1, geom_s2, geom_s3, geom_s4, geom_s5, geom_s6;
	logic signed [20:0] df_s1 [3];
	logic signed [29:0] ldrd_s2 [3];
	logic signed [35:0] dfl_s2 [3];
	logic signed [35:0] dfr_s2 [3];
	logic signed [30:0] a01_s3, a01_s4;
	logic signed [36:0] b0_s3, b1_s3;
	logic [60:0]        a01sq_s4;
	logic signed [28:0] b0h_s4, b1h_s4, b0h_s5, b1h_s5;
	logic signed [23:0] s0proj_s4, s0proj_s5, s0proj_s6;
	logic [31:0]        det_s5, det_s6;
	logic signed [59:0] pa0_s5, pa1_s5, n0_s6, n1_s6;
	logic               solve_s6;

	logic signed [36:0] b0r, b1r, b0p;
	logic [32:0]        a2;
	logic signed [33:0] dd;
	logic signed [59:0] n0_c, n1_c;
	logic               slv_c;

	// Stage 1: clamp the directions and take the origin difference.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				geom_s1.lo[i] <= lo_in[i];
				geom_s1.ro[i] <= ro_in[i];
				geom_s1.ld[i] <= clamp_dir(ld_in[i]);
				geom_s1.rd[i] <= clamp_dir(rd_in[i]);
				df_s1[i]      <= 21'(lo_in[i]) - 21'(ro_in[i]);
			end
		end
	end

	// Stage 2: per-axis products of the dot products.
	always_ff @(posedge clk) begin
		if (en) begin
			geom_s2 <= geom_s1;
			for (int i = 0; i < 3; i++) begin
				ldrd_s2[i] <= 30'($signed(geom_s1.ld[i])) * 30'($signed(geom_s1.rd[i]));
				dfl_s2[i]  <= 36'(df_s1[i]) * 36'($signed(geom_s1.ld[i]));
				dfr_s2[i]  <= 36'(df_s1[i]) * 36'($signed(geom_s1.rd[i]));
			end
		end
	end

	// Stage 3: sum the products into a01, b0 and b1.
	always_ff @(posedge clk) begin
		if (en) begin
			geom_s3 <= geom_s2;
			a01_s3  <= -(31'(ldrd_s2[0]) + 31'(ldrd_s2[1]) + 31'(ldrd_s2[2]));
			b0_s3   <= 37'(dfl_s2[0]) + 37'(dfl_s2[1]) + 37'(dfl_s2[2]);
			b1_s3   <= -(37'(dfr_s2[0]) + 37'(dfr_s2[1]) + 37'(dfr_s2[2]));
		end
	end

	// Stage 4: square a01, round b0 and b1, form the projection parameter.
	always_comb begin
		b0r = (b0_s3 + 37'sd128) >>> 8;
		b1r = (b1_s3 + 37'sd128) >>> 8;
		b0p = (b0_s3 + 37'sd8192) >>> 14;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			geom_s4   <= geom_s3;
			a01_s4    <= a01_s3;
			a01sq_s4  <= 61'(61'(a01_s3) * 61'(a01_s3));
			b0h_s4    <= 29'(b0r);
			b1h_s4    <= 29'(b1r);
			s0proj_s4 <= -24'(b0p);
		end
	end

	// Stage 5: determinant and the cross products for the numerators.
	always_comb begin
		a2 = 33'((a01sq_s4 + 61'd134217728) >> 28);
		dd = 34'sd268435456 - $signed({1'b0, a2});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			geom_s5   <= geom_s4;
			s0proj_s5 <= s0proj_s4;
			b0h_s5    <= b0h_s4;
			b1h_s5    <= b1h_s4;
			det_s5    <= dd[33] ? 32'(-dd) : 32'(dd);
			pa0_s5    <= 60'(a01_s4) * 60'(b0h_s4);
			pa1_s5    <= 60'(a01_s4) * 60'(b1h_s4);
		end
	end

	// Stage 6: numerators and the choice between solve and projection.
	always_comb begin
		n1_c  = pa0_s5 - (60'(b1h_s5) <<< 28);
		n0_c  = pa1_s5 - (60'(b0h_s5) <<< 28);
		slv_c = (det_s5 != 32'd0) && (det_s5 >= {3'd0, tol});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			geom_s6   <= geom_s5;
			s0proj_s6 <= s0proj_s5;
			det_s6    <= det_s5;
			n0_s6     <= n0_c;
			n1_s6     <= n1_c;
			solve_s6  <= slv_c && !n1_c[59];
		end
	end

	always_comb begin
		solved.side.geom    = geom_s6;
		solved.side.s0proj  = s0proj_s6;
		solved.side.use_div = solve_s6;
		solved.n0           = n0_s6;
		solved.n1           = n1_s6;
		solved.det          = det_s6;
	end

endmodule

`default_nettype wire

// File: src/lrd_div.sv
`timescale 1ns / 1ps
`default_nettype none

module lrd_div (
	input  wire logic               clk,
	input  wire logic               en,
	input  wire logic signed [59:0] num,
	input  wire logic [31:0]        det,
	output logic signed [31:0]      quo
);
	import lrd_pkg::*;

	logic [37:0] rem_q [DIV_STEPS + 1];
	logic [31:0] low_q [DIV_STEPS + 1];
	logic [31:0] qb_q  [DIV_STEPS + 1];
	logic [37:0] dvs_q [DIV_STEPS + 1];
	logic        neg_q [DIV_STEPS + 1];
	logic        ovf_q [DIV_STEPS + 1];
	logic signed [31:0] res_q;

	logic [59:0] mag, a_in;
	logic [37:0] dvs_in;
	logic [37:0] trial [DIV_STEPS + 1];
	logic        take  [DIV_STEPS + 1];
	logic [31:0] qf;

	// Rounded division: (|num| + 32 det) / (64 det), sign applied afterward.
	always_comb begin
		mag    = num[59] ? 60'(-num) : 60'(num);
		a_in   = mag + {23'd0, det, 5'd0};
		dvs_in = {det, 6'd0};
	end

	// One quotient bit per stage, restoring.
	always_comb begin
		trial[0] = '0;
		take[0]  = 1'b0;
		for (int k = 1; k <= DIV_STEPS; k++) begin
			trial[k] = {rem_q[k-1][36:0], low_q[k-1][31]};
			take[k]  = trial[k] >= dvs_q[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q[0] <= {10'd0, a_in[59:32]};
			low_q[0] <= a_in[31:0];
			qb_q[0]  <= '0;
			dvs_q[0] <= dvs_in;
			neg_q[0] <= num[59];
			ovf_q[0] <= {10'd0, a_in[59:32]} >= dvs_in;
			for (int k = 1; k <= DIV_STEPS; k++) begin
				rem_q[k] <= take[k] ? trial[k] - dvs_q[k-1] : trial[k];
				low_q[k] <= {low_q[k-1][30:0], 1'b0};
				qb_q[k]  <= {qb_q[k-1][30:0], take[k]};
				dvs_q[k] <= dvs_q[k-1];
				neg_q[k] <= neg_q[k-1];
				ovf_q[k] <= ovf_q[k-1];
			end
		end
	end

	// Apply the sign and saturate to 32 signed bits.
	always_comb begin
		qf = qb_q[DIV_STEPS];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (neg_q[DIV_STEPS]) begin
				if (ovf_q[DIV_STEPS] || qf > 32'h80000000) begin
					res_q <= 32'sh80000000;
				end else begin
					res_q <= -$signed(qf);
				end
			end else begin
				if (ovf_q[DIV_STEPS] || qf > 32'h7fffffff) begin
					res_q <= 32'sh7fffffff;
				end else begin
					res_q <= $signed(qf);
				end
			end
		end
	end

	assign quo = res_q;

endmodule

`default_nettype wire

// File: src/lrd_point.sv
`timescale 1ns / 1ps
`default_nettype none

module lrd_point (
	input  wire logic               clk,
	input  wire logic               en,
	input  wire lrd_pkg::side_t     side,
	input  wire logic signed [31:0] q0,
	input  wire logic signed [31:0] q1,
	output lrd_pkg::tail_t          tail
);
	import lrd_pkg::*;

	function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
		if (v > 34'sd2147483647) begin
			sat32 = 32'sh7fffffff;
		end else if (v < -34'sd2147483648) begin
			sat32 = 32'sh80000000;
		end else begin
			sat32 = 32'(v);
		end
	endfunction

	logic signed [31:0] s0_c, s1_c;
	logic signed [31:0] s0_s1, s0_s2, s0_s3, s0_s4, s0_s5;
	logic [30:0]        s1_s1, s1_s2, s1_s3, s1_s4, s1_s5;
	logic signed [19:0] lo_s1 [3];
	logic signed [19:0] ro_s1 [3];
	logic signed [47:0] pr0_s1 [3];
	logic signed [47:0] pr1_s1 [3];
	logic signed [33:0] p0_s2 [3];
	logic signed [33:0] p1_s2 [3];
	logic signed [34:0] dif [3];
	logic [34:0]        adf [3];
	logic [21:0]        dlo_s3 [3];
	logic               ovf_s3, ovf_s4;
	logic [2:0][31:0]   p0_s3, p0_s4, p0_s5, p1_s3, p1_s4, p1_s5;
	logic [43:0]        dsq_s4 [3];
	logic [41:0]        sq_s5;
	logic [45:0]        sum;

	// Stage 1: pick the parameters and scale the directions by them.
	always_comb begin
		s0_c = side.use_div ? q0 : 32'(side.s0proj);
		s1_c = side.use_div ? {1'b0, q1[30:0]} : 32'sd0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s0_s1 <= s0_c;
			s1_s1 <= s1_c[30:0];
			for (int i = 0; i < 3; i++) begin
				lo_s1[i]  <= $signed(side.geom.lo[i]);
				ro_s1[i]  <= $signed(side.geom.ro[i]);
				pr0_s1[i] <= 48'(s0_c) * 48'($signed(side.geom.ld[i]));
				pr1_s1[i] <= 48'(s1_c) * 48'($signed(side.geom.rd[i]));
			end
		end
	end

	// Stage 2: closest points, rounded to Q.8.
	always_ff @(posedge clk) begin
		if (en) begin
			s0_s2 <= s0_s1;
			s1_s2 <= s1_s1;
			for (int i = 0; i < 3; i++) begin
				p0_s2[i] <= 34'(((48'(lo_s1[i]) <<< 14) + pr0_s1[i] + 48'sd8192) >>> 14);
				p1_s2[i] <= 34'(((48'(ro_s1[i]) <<< 14) + pr1_s1[i] + 48'sd8192) >>> 14);
			end
		end
	end

	// Stage 3: per-axis separation and its range check.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dif[i] = 35'(p0_s2[i]) - 35'(p1_s2[i]);
			adf[i] = dif[i][34] ? 35'(-dif[i]) : 35'(dif[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s0_s3  <= s0_s2;
			s1_s3  <= s1_s2;
			ovf_s3 <= (|adf[0][34:22]) || (|adf[1][34:22]) || (|adf[2][34:22]);
			for (int i = 0; i < 3; i++) begin
				dlo_s3[i] <= adf[i][21:0];
				p0_s3[i]  <= sat32(p0_s2[i]);
				p1_s3[i]  <= sat32(p1_s2[i]);
			end
		end
	end

	// Stage 4: square each separation.
	always_ff @(posedge clk) begin
		if (en) begin
			s0_s4  <= s0_s3;
			s1_s4  <= s1_s3;
			ovf_s4 <= ovf_s3;
			p0_s4  <= p0_s3;
			p1_s4  <= p1_s3;
			for (int i = 0; i < 3; i++) begin
				dsq_s4[i] <= 44'(dlo_s3[i]) * 44'(dlo_s3[i]);
			end
		end
	end

	// Stage 5: sum and saturate the squared distance.
	always_comb begin
		sum = 46'(dsq_s4[0]) + 46'(dsq_s4[1]) + 46'(dsq_s4[2]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s0_s5 <= s0_s4;
			s1_s5 <= s1_s4;
			p0_s5 <= p0_s4;
			p1_s5 <= p1_s4;
			sq_s5 <= (ovf_s4 || sum > 46'(SQ_MAX)) ? SQ_MAX : sum[41:0];
		end
	end

	always_comb begin
		tail.sq = sq_s5;
		tail.s0 = s0_s5;
		tail.s1 = s1_s5;
		tail.p0 = p0_s5;
		tail.p1 = p1_s5;
	end

endmodule

`default_nettype wire

// File: src/lrd_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none

module lrd_sqrt (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [41:0] val,
	output logic [20:0]      root
);
	import lrd_pkg::*;

	logic [22:0] rem_q  [SQRT_LAT];
	logic [20:0] rt_q   [SQRT_LAT];
	logic [41:0] rest_q [SQRT_LAT];

	logic [22:0] rem_in  [SQRT_LAT];
	logic [20:0] rt_in   [SQRT_LAT];
	logic [41:0] rest_in [SQRT_LAT];
	logic [24:0] part    [SQRT_LAT];
	logic [24:0] trial   [SQRT_LAT];
	logic        take    [SQRT_LAT];

	// One root bit per stage, two radicand bits brought down each time.
	always_comb begin
		for (int k = 0; k < SQRT_LAT; k++) begin
			if (k == 0) begin
				rem_in[k]  = '0;
				rt_in[k]   = '0;
				rest_in[k] = val;
			end else begin
				rem_in[k]  = rem_q[k-1];
				rt_in[k]   = rt_q[k-1];
				rest_in[k] = rest_q[k-1];
			end
			part[k]  = {rem_in[k], rest_in[k][41:40]};
			trial[k] = {2'd0, rt_in[k], 2'b01};
			take[k]  = part[k] >= trial[k];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < SQRT_LAT; k++) begin
				rem_q[k]  <= take[k] ? 23'(part[k] - trial[k]) : part[k][22:0];
				rt_q[k]   <= {rt_in[k][19:0], take[k]};
				rest_q[k] <= {rest_in[k][39:0], 2'b00};
			end
		end
	end

	assign root = rt_q[SQRT_LAT-1];

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
	import lrd_pkg::*;

	localparam int LATENCY   = PIPE_LAT;
	localparam int IDLE_LIMIT = 20000;

	logic        clk;
	logic        arst_n;
	logic        query_valid;
	logic        query_ready;
	query_t      query;
	logic        result_valid;
	logic        result_ready;
	result_t     result;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [28:0] cfg_data;

	line_ray_distance_3d_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.query_valid(query_valid),
		.query_ready(query_ready),
		.query(query),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	// Free-running clock.
	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	result_t     pending_results[$];
	logic [28:0] tolerance;
	int          error_count;
	int          idle_cycles;
	int          hold_cycles;
	bit          random_stall;

	// Rounded right shift, ties toward plus infinity.
	function automatic longint round_shift(longint x, int n);
		longint y;
		y = x + (64'sd1 <<< (n - 1));
		return y >>> n;
	endfunction

	// Rounded division, ties away from zero.
	function automatic longint round_div(longint n, longint d);
		longint a, q;
		a = (n < 0) ? -n : n;
		q = (a + d / 2) / d;
		return (n < 0) ? -q : q;
	endfunction

	function automatic longint sat_s32(longint x);
		if (x > 64'sd2147483647) return 64'sd2147483647;
		if (x < -64'sd2147483648) return -64'sd2147483648;
		return x;
	endfunction

	function automatic longint clamp_dir(logic signed [15:0] v);
		longint d;
		d = v;
		if (d > 16384) return 16384;
		if (d < -16384) return -16384;
		return d;
	endfunction

	function automatic longint int_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// Closest approach of line and ray, bit exact.
	function automatic result_t closest_approach(query_t q, logic [28:0] tol);
		longint lo[3], ld[3], ro[3], rd[3], df[3], p0[3], p1[3];
		longint a01, b0, b1, det, s0, s1, a2, b0h, b1h, n0, n1, d;
		longint unsigned sq, sqm;
		bit over;
		result_t r;
		lo[0] = q.line_origin_x; lo[1] = q.line_origin_y; lo[2] = q.line_origin_z;
		ro[0] = q.ray_origin_x;  ro[1] = q.ray_origin_y;  ro[2] = q.ray_origin_z;
		ld[0] = clamp_dir(q.line_dir_x);
		ld[1] = clamp_dir(q.line_dir_y);
		ld[2] = clamp_dir(q.line_dir_z);
		rd[0] = clamp_dir(q.ray_dir_x);
		rd[1] = clamp_dir(q.ray_dir_y);
		rd[2] = clamp_dir(q.ray_dir_z);
		a01 = 0; b0 = 0; b1 = 0;
		for (int i = 0; i < 3; i++) begin
			df[i] = lo[i] - ro[i];
			a01 -= ld[i] * rd[i];
			b0 += df[i] * ld[i];
			b1 -= df[i] * rd[i];
		end
		a2 = (a01 * a01 + (64'sd1 <<< 27)) >>> 28;
		det = (64'sd1 <<< 28) - a2;
		if (det < 0) det = -det;
		s0 = -round_shift(b0, 14);
		s1 = 0;
		if (det != 0 && det >= longint'(tol)) begin
			b0h = round_shift(b0, 8);
			b1h = round_shift(b1, 8);
			n1 = a01 * b0h - b1h * (64'sd1 <<< 28);
			if (n1 >= 0) begin
				n0 = a01 * b1h - b0h * (64'sd1 <<< 28);
				s0 = round_div(n0, det * 64);
				s1 = round_div(n1, det * 64);
			end
		end
		s0 = sat_s32(s0);
		if (s1 > 64'sd2147483647) s1 = 64'sd2147483647;
		sq = 0;
		over = 0;
		for (int i = 0; i < 3; i++) begin
			p0[i] = round_shift(lo[i] * 16384 + s0 * ld[i], 14);
			p1[i] = round_shift(ro[i] * 16384 + s1 * rd[i], 14);
			d = p0[i] - p1[i];
			if (d < 0) d = -d;
			if (d >= (64'sd1 <<< 22)) over = 1;
			else sq += d * d;
		end
		sqm = (64'd1 << 42) - 1;
		if (over || sq > sqm) sq = sqm;
		r.squared_distance = sq[41:0];
		r.distance = 21'(int_sqrt(sq));
		r.line_param = 32'(s0);
		r.ray_param = 31'(s1);
		r.near_x = 32'(sat_s32(p0[0]));
		r.near_y = 32'(sat_s32(p0[1]));
		r.near_z = 32'(sat_s32(p0[2]));
		r.far_x = 32'(sat_s32(p1[0]));
		r.far_y = 32'(sat_s32(p1[1]));
		r.far_z = 32'(sat_s32(p1[2]));
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		error_count++;
	endtask

	// Short gaps mostly, a few long ones.
	function automatic int gap_len();
		if ($urandom_range(9) == 0) return $urandom_range(40, 5);
		if ($urandom_range(2) == 0) return 0;
		return $urandom_range(2);
	endfunction

	task automatic send_query(query_t q);
		query_valid <= 1'b1;
		query <= q;
		do @(posedge clk); while (!query_ready);
		pending_results.push_back(closest_approach(q, tolerance));
		if (random_stall) begin
			int g;
			g = gap_len();
			if (g > 0) begin
				query_valid <= 1'b0;
				repeat (g) @(posedge clk);
			end
		end
	endtask

	task automatic finish_query_burst();
		query_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		while (pending_results.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic write_tolerance(logic [28:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		tolerance = v;
		@(posedge clk);
	endtask

	function automatic logic signed [15:0] rand_dir();
		case ($urandom_range(5))
			0: return 16'sd16384;
			1: return -16'sd16384;
			2: return 16'sd0;
			3: return 16'($urandom);
			default: return 16'($signed($urandom_range(32768)) - 16384);
		endcase
	endfunction

	function automatic logic signed [19:0] rand_coord();
		case ($urandom_range(4))
			0: return 20'sh7ffff;
			1: return 20'sh80000;
			2: return 20'($urandom_range(2047)) - 20'sd1024;
			default: return 20'($urandom);
		endcase
	endfunction

	// Unit-ish directions: pick one, then derive a nearby or skew partner.
	function automatic query_t rand_query();
		query_t q;
		q = '0;
		q.line_origin_x = rand_coord();
		q.line_origin_y = rand_coord();
		q.line_origin_z = rand_coord();
		q.ray_origin_x = rand_coord();
		q.ray_origin_y = rand_coord();
		q.ray_origin_z = rand_coord();
		q.line_dir_x = rand_dir();
		q.line_dir_y = rand_dir();
		q.line_dir_z = rand_dir();
		if ($urandom_range(3) == 0) begin
			q.ray_dir_x = q.line_dir_x + 16'($signed($urandom_range(8)) - 4);
			q.ray_dir_y = q.line_dir_y;
			q.ray_dir_z = q.line_dir_z;
		end else begin
			q.ray_dir_x = rand_dir();
			q.ray_dir_y = rand_dir();
			q.ray_dir_z = rand_dir();
		end
		return q;
	endfunction

	// Result checker and receiver stall.
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && result_ready) begin
				result_t w;
				if (pending_results.size() == 0) begin
					$display("unexpected result transaction");
					error_count++;
				end else begin
					w = pending_results.pop_front();
					if (result.squared_distance !== w.squared_distance)
						report_mismatch("squared_distance", result.squared_distance,
							w.squared_distance);
					if (result.distance !== w.distance)
						report_mismatch("distance", result.distance, w.distance);
					if (result.line_param !== w.line_param)
						report_mismatch("line_param", result.line_param, w.line_param);
					if (result.ray_param !== w.ray_param)
						report_mismatch("ray_param", result.ray_param, w.ray_param);
					if (result.near_x !== w.near_x)
						report_mismatch("near_x", result.near_x, w.near_x);
					if (result.near_y !== w.near_y)
						report_mismatch("near_y", result.near_y, w.near_y);
					if (result.near_z !== w.near_z)
						report_mismatch("near_z", result.near_z, w.near_z);
					if (result.far_x !== w.far_x)
						report_mismatch("far_x", result.far_x, w.far_x);
					if (result.far_y !== w.far_y)
						report_mismatch("far_y", result.far_y, w.far_y);
					if (result.far_z !== w.far_z)
						report_mismatch("far_z", result.far_z, w.far_z);
				end
			end
			if (hold_cycles > 0) begin
				hold_cycles <= hold_cycles - 1;
				result_ready <= 1'b0;
			end else if (random_stall) begin
				result_ready <= (gap_len() == 0);
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	// Watchdog on cycles with no transaction at all.
	always @(posedge clk) begin
		if ((query_valid && query_ready) || (result_valid && result_ready)
				|| (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("** line_ray_distance_3d_core: FAILED **");
			$finish;
		end
	end

	task automatic test_directed_cases();
		query_t q;
		// Identical line and ray: zero determinant.
		q = '0;
		q.line_dir_x = 16'sd16384;
		q.ray_dir_x = 16'sd16384;
		send_query(q);
		// Perpendicular axes with offsets.
		q.ray_dir_x = 16'sd0;
		q.ray_dir_y = 16'sd16384;
		q.ray_origin_z = 20'sd2560;
		q.ray_origin_x = 20'sd256;
		send_query(q);
		// Negative ray parameter forces the projection.
		q.ray_origin_y = 20'sd2560;
		send_query(q);
		// Extreme origins, opposite corners.
		q.line_origin_x = 20'sh7ffff; q.line_origin_y = 20'sh7ffff;
		q.line_origin_z = 20'sh7ffff;
		q.ray_origin_x = 20'sh80000; q.ray_origin_y = 20'sh80000;
		q.ray_origin_z = 20'sh80000;
		q.line_dir_x = 16'sd11585; q.line_dir_y = 16'sd11585; q.line_dir_z = 16'sd0;
		q.ray_dir_x = -16'sd16384; q.ray_dir_y = 16'sd0; q.ray_dir_z = 16'sd0;
		send_query(q);
		// Directions out of range are clamped.
		q.line_dir_x = 16'sh7fff; q.line_dir_y = 16'sh8000; q.line_dir_z = 16'sh7fff;
		q.ray_dir_x = 16'sh8000; q.ray_dir_y = 16'sh7fff; q.ray_dir_z = 16'sh8000;
		send_query(q);
		q.line_dir_x = -16'sd16384; q.line_dir_y = 16'sd0; q.line_dir_z = 16'sd0;
		q.ray_dir_x = 16'sd16384; q.ray_dir_y = 16'sd0; q.ray_dir_z = 16'sd0;
		send_query(q);
		// Nearly parallel, big offsets: parameter saturation.
		q.ray_dir_x = -16'sd16383; q.ray_dir_y = 16'sd181;
		send_query(q);
		q.ray_dir_y = -16'sd181; q.ray_dir_x = -16'sd16384;
		send_query(q);
		for (int i = 0; i < 12; i++) send_query(rand_query());
		finish_query_burst();
		wait_drained();
	endtask

	task automatic test_tolerance_sweep();
		logic [28:0] levels[5];
		levels[0] = 29'd0;
		levels[1] = 29'd268435456;
		levels[2] = 29'd1000000;
		levels[3] = 29'h1fffffff;
		levels[4] = 29'd268;
		foreach (levels[k]) begin
			write_tolerance(levels[k]);
			for (int i = 0; i < 60; i++) send_query(rand_query());
			finish_query_burst();
			wait_drained();
		end
	endtask

	// Receiver holds off while the sender keeps offering.
	task automatic test_backpressure();
		hold_cycles = 300;
		for (int i = 0; i < 150; i++) send_query(rand_query());
		finish_query_burst();
		wait_drained();
	endtask

	task automatic test_random_traffic();
		for (int i = 0; i < 780; i++) begin
			random_stall = ($urandom_range(7) != 0);
			send_query(rand_query());
		end
		random_stall = 1;
		finish_query_burst();
	endtask

	initial begin
		arst_n = 1'b0;
		query_valid = 1'b0;
		query = '0;
		result_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		tolerance = TOL_RESET;
		error_count = 0;
		idle_cycles = 0;
		hold_cycles = 0;
		random_stall = 1;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_tolerance_sweep();
		test_backpressure();
		test_random_traffic();
		wait_drained();
		if (error_count == 0)
			$display("** line_ray_distance_3d_core: PASSED **");
		else
			$display("** line_ray_distance_3d_core: FAILED **");
		$finish;
	end

endmodule

// File: filelist.f
src/lrd_pkg.sv
src/lrd_setup.sv
src/lrd_div.sv
src/lrd_point.sv
src/lrd_sqrt.sv
src/line_ray_distance_3d_core.sv
tb/sv/tb.sv
